### hw/rtl/ams_pkg.sv
// Shared types, constants and codes for the adjacency matrix store.
package ams_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_BITS   = $clog2(MAX_VERTICES);
  localparam int ADDR_BITS  = 2 * VTX_BITS;
  localparam int MEM_DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);

  // Fixed port widths of the block.
  localparam int FUNC_BITS  = 2;
  localparam int PORT_VTX   = 6;
  localparam int IO_WEIGHT  = 16;
  localparam int EC_BITS    = 16;
  localparam int CFG_BITS   = 7;
  localparam int CMP_BITS   = 8;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);
  localparam logic [EC_BITS-1:0]  EC_MAX    = {EC_BITS{1'b1}};

  localparam longint WGT_MAX = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
  localparam longint WGT_MIN = -WGT_MAX - 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD  = 2'd0,
    FN_GET  = 2'd1,
    FN_CONN = 2'd2,
    FN_LIST = 2'd3
  } func_t;

  // One classified operation, passed from the front to the back.
  typedef struct packed {
    func_t                         func;
    logic [VTX_BITS-1:0]           row;
    logic [VTX_BITS-1:0]           col;
    logic signed [WEIGHT_BITS-1:0] wgt;
    logic                          range_err;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic signed [IO_WEIGHT-1:0] read_weight;
    logic                        connected;
    logic [PORT_VTX-1:0]         neighbor;
    logic                        neighbor_valid;
    logic [EC_BITS-1:0]          edge_count;
    logic                        range_error;
    logic                        last;
  } res_t;

endpackage

### hw/rtl/ams_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ams_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ams_front.sv
// Front end: vertex count register, range check and operation classification.
module ams_front import ams_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [FUNC_BITS-1:0]  in_func,
  input  logic [PORT_VTX-1:0]   in_from_vertex,
  input  logic [PORT_VTX-1:0]   in_to_vertex,
  input  logic signed [IO_WEIGHT-1:0] in_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_vertex_count,
  input  logic                  clearing,
  input  logic                  cq_full,
  output logic                  cq_push,
  output cmd_t                  cq_din,
  output logic [CNT_BITS-1:0]   eff_cnt
);

  logic [CFG_BITS-1:0] vcount_r;
  logic [CFG_BITS-1:0] vcount_nxt;
  logic                row_ok;
  logic                col_ok;
  func_t               fn;

  // Clamp an input weight into the signed range of the store.
  function automatic logic signed [WEIGHT_BITS-1:0] fit_weight(
    input logic signed [IO_WEIGHT-1:0] w
  );
    logic signed [32:0] v;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    v  = 33'(w);
    hi = 33'(WGT_MAX);
    lo = 33'(WGT_MIN);
    if (v > hi) begin
      v = hi;
    end
    if (v < lo) begin
      v = lo;
    end
    return WEIGHT_BITS'(v);
  endfunction

  assign cfg_ready  = 1'b1;
  assign vcount_nxt = (cfg_valid && cfg_ready) ? cfg_vertex_count : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CFG_RESET;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  assign eff_cnt = (vcount_r > CFG_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
                                                        : CNT_BITS'(vcount_r);

  assign fn     = func_t'(in_func);
  assign row_ok = CMP_BITS'(in_from_vertex) < CMP_BITS'(eff_cnt);
  assign col_ok = CMP_BITS'(in_to_vertex) < CMP_BITS'(eff_cnt);

  always_comb begin
    cq_din           = '0;
    cq_din.func      = fn;
    cq_din.row       = VTX_BITS'(in_from_vertex);
    cq_din.col       = VTX_BITS'(in_to_vertex);
    cq_din.wgt       = fit_weight(in_weight);
    cq_din.range_err = !row_ok || ((fn != FN_LIST) && !col_ok);
  end

  assign full    = cq_full || clearing;
  assign cq_push = push && !full;

endmodule

### hw/rtl/ams_cmd_queue.sv
// Short queue of classified operations between the front and the back.
module ams_cmd_queue import ams_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_BITS = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

  cmd_t                   mem_r [CMDQ_DEPTH];
  logic [PTR_BITS-1:0]    wptr_r;
  logic [PTR_BITS-1:0]    rptr_r;
  logic [CQ_CNT_BITS-1:0] cnt_r;
  logic                   do_push;
  logic                   do_pop;

  assign full    = cnt_r == CQ_CNT_BITS'(CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + PTR_BITS'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CQ_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CQ_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

### hw/rtl/ams_back.sv
// Back end: clears the matrix, executes operations and queues the results.
module ams_back import ams_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cq_empty,
  input  cmd_t                cq_dout,
  output logic                cq_pop,
  input  logic [CNT_BITS-1:0] eff_cnt,
  output logic                clearing,
  input  logic                pop,
  output logic                empty,
  output res_t                res_head
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  localparam int RQ_PTR_BITS = $clog2(RESQ_DEPTH);
  localparam int RQ_CNT_BITS = $clog2(RESQ_DEPTH + 1);

  state_t                   state_r, state_nxt;
  logic [ADDR_BITS-1:0]     clr_addr_r, clr_addr_nxt;
  cmd_t                     cur_r, cur_nxt;
  logic [VTX_BITS-1:0]      scan_col_r, scan_col_nxt;
  logic [VTX_BITS-1:0]      pend_r, pend_nxt;
  logic                     have_pend_r, have_pend_nxt;
  logic [EC_BITS-1:0]       edge_cnt_r, edge_cnt_nxt;

  res_t                     rq_mem_r [RESQ_DEPTH];
  logic [RQ_PTR_BITS-1:0]   rq_wptr_r;
  logic [RQ_PTR_BITS-1:0]   rq_rptr_r;
  logic [RQ_CNT_BITS-1:0]   rq_cnt_r;
  logic                     rq_space;
  logic                     res_push;
  res_t                     res_d;
  logic                     res_pop;

  logic                          ram_we;
  logic [ADDR_BITS-1:0]          ram_waddr;
  logic [WEIGHT_BITS-1:0]        ram_wdata;
  logic                          ram_re;
  logic [ADDR_BITS-1:0]          ram_raddr;
  logic [WEIGHT_BITS-1:0]        ram_rdata;
  logic                          nz;
  logic                          more_cols;

  // Sign-extend a stored weight and keep the bits of the result port.
  function automatic logic [IO_WEIGHT-1:0] io_weight(
    input logic signed [WEIGHT_BITS-1:0] w
  );
    logic signed [31:0] x;
    x = 32'(w);
    return x[IO_WEIGHT-1:0];
  endfunction

  ams_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing  = state_r == ST_CLEAR;
  assign rq_space  = rq_cnt_r != RQ_CNT_BITS'(RESQ_DEPTH);
  assign empty     = rq_cnt_r == '0;
  assign res_pop   = pop && !empty;
  assign res_head  = rq_mem_r[rq_rptr_r];
  assign nz        = |ram_rdata;
  assign more_cols = (CNT_BITS'(scan_col_r) + CNT_BITS'(1)) < eff_cnt;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_nxt       = cur_r;
    scan_col_nxt  = scan_col_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    edge_cnt_nxt  = edge_cnt_r;
    cq_pop        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {cq_dout.row, cq_dout.col};
    ram_wdata     = cq_dout.wgt;
    ram_re        = 1'b0;
    ram_raddr     = {cq_dout.row, cq_dout.col};
    res_push      = 1'b0;
    res_d            = '0;
    res_d.edge_count = edge_cnt_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_BITS'(1);
        if (clr_addr_r == {ADDR_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!cq_empty) begin
          if (cq_dout.range_err) begin
            if (rq_space) begin
              res_push          = 1'b1;
              res_d.range_error = 1'b1;
              res_d.last        = 1'b1;
              cq_pop            = 1'b1;
            end
          end else begin
            unique case (cq_dout.func)
              FN_ADD: begin
                if (rq_space) begin
                  ram_we = 1'b1;
                  if (edge_cnt_r != EC_MAX) begin
                    edge_cnt_nxt = edge_cnt_r + EC_BITS'(1);
                  end
                  res_push         = 1'b1;
                  res_d.edge_count = edge_cnt_nxt;
                  res_d.last       = 1'b1;
                  cq_pop           = 1'b1;
                end
              end
              FN_GET, FN_CONN: begin
                ram_re    = 1'b1;
                cur_nxt   = cq_dout;
                cq_pop    = 1'b1;
                state_nxt = ST_LOOKUP;
              end
              FN_LIST: begin
                ram_re        = 1'b1;
                ram_raddr     = {cq_dout.row, {VTX_BITS{1'b0}}};
                cur_nxt       = cq_dout;
                scan_col_nxt  = '0;
                have_pend_nxt = 1'b0;
                cq_pop        = 1'b1;
                state_nxt     = ST_SCAN;
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
          end
        end
      end

      ST_LOOKUP: begin
        // Read data holds until the next read, so a full result queue just waits.
        if (rq_space) begin
          res_push        = 1'b1;
          res_d.connected = nz;
          res_d.last      = 1'b1;
          if (cur_r.func == FN_GET) begin
            res_d.read_weight = io_weight(ram_rdata);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // A found neighbor is held back until the next one is found, so the final one can carry last.
        if (!(nz && have_pend_r && !rq_space)) begin
          if (nz) begin
            if (have_pend_r) begin
              res_push             = 1'b1;
              res_d.connected      = 1'b1;
              res_d.neighbor       = PORT_VTX'(pend_r);
              res_d.neighbor_valid = 1'b1;
            end
            pend_nxt      = scan_col_r;
            have_pend_nxt = 1'b1;
          end
          if (more_cols) begin
            ram_re       = 1'b1;
            ram_raddr    = {cur_r.row, scan_col_r + VTX_BITS'(1)};
            scan_col_nxt = scan_col_r + VTX_BITS'(1);
          end else begin
            state_nxt = ST_SCAN_END;
          end
        end
      end

      ST_SCAN_END: begin
        if (rq_space) begin
          res_push   = 1'b1;
          res_d.last = 1'b1;
          if (have_pend_r) begin
            res_d.connected      = 1'b1;
            res_d.neighbor       = PORT_VTX'(pend_r);
            res_d.neighbor_valid = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      have_pend_r <= 1'b0;
      edge_cnt_r  <= '0;
      rq_wptr_r   <= '0;
      rq_rptr_r   <= '0;
      rq_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      have_pend_r <= have_pend_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      if (res_push) begin
        rq_wptr_r <= rq_wptr_r + RQ_PTR_BITS'(1);
      end
      if (res_pop) begin
        rq_rptr_r <= rq_rptr_r + RQ_PTR_BITS'(1);
      end
      if (res_push && !res_pop) begin
        rq_cnt_r <= rq_cnt_r + RQ_CNT_BITS'(1);
      end else if (res_pop && !res_push) begin
        rq_cnt_r <= rq_cnt_r - RQ_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    scan_col_r <= scan_col_nxt;
    pend_r     <= pend_nxt;
    if (res_push) begin
      rq_mem_r[rq_wptr_r] <= res_d;
    end
  end

endmodule

### hw/rtl/adjacency_matrix_store.sv
// Top level of the adjacency matrix store: front end, operation queue and back end.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         push / full               in_func, in_from_vertex, in_to_vertex,
//                                                  in_weight
//   result    out        empty / pop               out_read_weight, out_connected,
//                                                  out_neighbor, out_neighbor_valid,
//                                                  out_edge_count, out_range_error, out_last
//   config    in         cfg_valid / cfg_ready     cfg_vertex_count
//
// After reset the back end zeroes the whole matrix, one entry per cycle; full stays
// high during that pass, while configuration writes are taken.
// Once accepted, an add edge or an out-of-range operation is done in the back end's
// idle state, a weight lookup reads and then answers from the lookup state, and a
// neighbor list scans its row up to the vertex count via the single matrix read port.
// A two-entry operation queue sits between the front and back ends, and a two-entry
// result queue drives the result ports, so either side may stall on its own.
module adjacency_matrix_store import ams_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [FUNC_BITS-1:0]        in_func,
  input  logic [PORT_VTX-1:0]         in_from_vertex,
  input  logic [PORT_VTX-1:0]         in_to_vertex,
  input  logic signed [IO_WEIGHT-1:0] in_weight,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [IO_WEIGHT-1:0] out_read_weight,
  output logic                        out_connected,
  output logic [PORT_VTX-1:0]         out_neighbor,
  output logic                        out_neighbor_valid,
  output logic [EC_BITS-1:0]          out_edge_count,
  output logic                        out_range_error,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_BITS-1:0]         cfg_vertex_count
);

  logic                clearing;
  logic                cq_full;
  logic                cq_push;
  cmd_t                cq_din;
  logic                cq_empty;
  logic                cq_pop;
  cmd_t                cq_dout;
  logic [CNT_BITS-1:0] eff_cnt;
  res_t                res_head;

  // The front end checks vertex indices against the configured count at transfer; the
  // user must change the count only while the block is idle, which it does not enforce.
  ams_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_weight        (in_weight),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .clearing         (clearing),
    .cq_full          (cq_full),
    .cq_push          (cq_push),
    .cq_din           (cq_din),
    .eff_cnt          (eff_cnt)
  );

  ams_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty)
  );

  // The back end owns the matrix memory, the edge counter and the result queue.
  ams_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_dout  (cq_dout),
    .cq_pop   (cq_pop),
    .eff_cnt  (eff_cnt),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .res_head (res_head)
  );

  assign out_read_weight    = res_head.read_weight;
  assign out_connected      = res_head.connected;
  assign out_neighbor       = res_head.neighbor;
  assign out_neighbor_valid = res_head.neighbor_valid;
  assign out_edge_count     = res_head.edge_count;
  assign out_range_error    = res_head.range_error;
  assign out_last           = res_head.last;

endmodule
